// ===== src/cmac_pkg.sv =====
// ----------------------------------------------------------------------------
// cmac_pkg: shared types and constants of the complex MAC ALU
// Operand and accumulator formats, command codes and channel payloads.
// ----------------------------------------------------------------------------
package cmac_pkg;

  // Operands are Q1.15, the accumulator Q10.30.
  localparam int OP_W    = 16;
  localparam int ACC_W   = 40;
  localparam int CMD_W   = 4;
  // Operand after conjugation: one extra bit holds the negated minimum.
  localparam int OPX_W   = OP_W + 1;
  localparam int PROD_W  = 2 * OPX_W;
  localparam int FRAC_SH = OP_W - 1;
  localparam int SUM_W   = ((ACC_W > PROD_W) ? ACC_W : PROD_W) + 2;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_COPY          = 4'd0,
    CMD_ADD           = 4'd1,
    CMD_SUB           = 4'd2,
    CMD_MUL           = 4'd3,
    CMD_SCALE         = 4'd4,
    CMD_ACC_ADD       = 4'd5,
    CMD_ACC_SUB       = 4'd6,
    CMD_MAC           = 4'd7,
    CMD_MSC           = 4'd8,
    CMD_MAC_I         = 4'd9,
    CMD_MSC_I         = 4'd10,
    CMD_TIMES_I       = 4'd11,
    CMD_TIMES_MINUS_I = 4'd12,
    CMD_NORM2         = 4'd13
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic                    conj_first;
    logic                    conj_second;
    logic signed [OP_W-1:0]  first_re;
    logic signed [OP_W-1:0]  first_im;
    logic signed [OP_W-1:0]  second_re;
    logic signed [OP_W-1:0]  second_im;
    logic signed [OP_W-1:0]  real_factor;
  } cmac_in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] result_re;
    logic signed [ACC_W-1:0] result_im;
    logic                    saturated;
  } cmac_out_t;

endpackage

// ===== src/cmac_in_if.sv =====
// ----------------------------------------------------------------------------
// cmac_in_if: command channel of the complex MAC ALU
// Valid/ready channel carrying one command with its operands.
// ----------------------------------------------------------------------------
interface cmac_in_if import cmac_pkg::*; ();

  logic     valid;
  logic     ready;
  cmac_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ===== src/cmac_out_if.sv =====
// ----------------------------------------------------------------------------
// cmac_out_if: result channel of the complex MAC ALU
// Valid/ready channel carrying the accumulator after each command.
// ----------------------------------------------------------------------------
interface cmac_out_if import cmac_pkg::*; ();

  logic      valid;
  logic      ready;
  cmac_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ===== src/complex_mac_alu_top.sv =====
// ----------------------------------------------------------------------------
// complex_mac_alu_top: fixed-point complex ALU with saturating accumulator
//
//   channel  | direction | carries
//   ---------+-----------+---------------------------------------------
//   in_i     | sink      | command, conjugate flags, operands, factor
//   out_o    | source    | accumulator re/im (Q10.30), saturated flag
//
// One command per cycle sustained while out_o is not stalled; a command
// passes from the input register to the result register through four
// 17x17 multipliers, a three-term add and the clamp. Reset clears both
// valid flags and the accumulator. A stalled result holds the accumulator;
// the input register still fills.
// ----------------------------------------------------------------------------
module complex_mac_alu_top import cmac_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cmac_in_if.sink    in_i,
  cmac_out_if.source out_o
);

  logic                    in_vld_q;
  cmac_in_t                in_q;
  logic                    out_vld_q;
  logic signed [ACC_W-1:0] acc_re_q, acc_re_d;
  logic signed [ACC_W-1:0] acc_im_q, acc_im_d;
  logic                    sat_q, sat_d;
  logic                    advance;
  logic                    in_xfer;

  logic signed [OPX_W-1:0]  ar, ai, br, bi, rf;
  logic signed [OPX_W-1:0]  m0_b, m1_b;
  logic signed [PROD_W-1:0] m0, m1, m2, m3;
  logic signed [SUM_W-1:0]  ar_al, ai_al, br_al, bi_al;
  logic signed [SUM_W-1:0]  p0, p1, p2, p3, acc_re_x, acc_im_x;
  logic signed [SUM_W-1:0]  re_t0, re_t1, re_t2, im_t0, im_t1, im_t2;
  logic signed [SUM_W-1:0]  sum_re, sum_im;
  logic [SUM_W-ACC_W:0]     re_top, im_top;
  logic                     re_fit, im_fit;

  // The result register advances when empty or when its transfer completes.
  assign advance    = !out_vld_q || out_o.ready;
  assign in_i.ready = !in_vld_q || advance;
  assign in_xfer    = in_i.valid && in_i.ready;

  // Operand decode, conjugate into one extra bit.
  always_comb begin
    ar = OPX_W'(in_q.first_re);
    ai = in_q.conj_first  ? -OPX_W'(in_q.first_im)  : OPX_W'(in_q.first_im);
    br = OPX_W'(in_q.second_re);
    bi = in_q.conj_second ? -OPX_W'(in_q.second_im) : OPX_W'(in_q.second_im);
    rf = OPX_W'(in_q.real_factor);
  end

  // Four shared multipliers: scale and norm2 reuse the first two.
  always_comb begin
    m0_b = br;
    m1_b = bi;
    if (in_q.command == CMD_SCALE) begin
      m0_b = rf;
      m1_b = rf;
    end else if (in_q.command == CMD_NORM2) begin
      m0_b = ar;
      m1_b = ai;
    end
    m0 = PROD_W'(ar) * PROD_W'(m0_b);
    m1 = PROD_W'(ai) * PROD_W'(m1_b);
    m2 = PROD_W'(ar) * PROD_W'(bi);
    m3 = PROD_W'(ai) * PROD_W'(br);
  end

  always_comb begin
    ar_al    = SUM_W'(ar) <<< FRAC_SH;
    ai_al    = SUM_W'(ai) <<< FRAC_SH;
    br_al    = SUM_W'(br) <<< FRAC_SH;
    bi_al    = SUM_W'(bi) <<< FRAC_SH;
    p0       = SUM_W'(m0);
    p1       = SUM_W'(m1);
    p2       = SUM_W'(m2);
    p3       = SUM_W'(m3);
    acc_re_x = SUM_W'(acc_re_q);
    acc_im_x = SUM_W'(acc_im_q);
  end

  // Term selection: product re = p0 - p1, product im = p2 + p3.
  always_comb begin
    re_t0 = '0;
    re_t1 = '0;
    re_t2 = '0;
    im_t0 = '0;
    im_t1 = '0;
    im_t2 = '0;
    unique case (in_q.command)
      CMD_COPY: begin
        re_t0 = ar_al;
        im_t0 = ai_al;
      end
      CMD_ADD: begin
        re_t0 = ar_al;  re_t1 = br_al;
        im_t0 = ai_al;  im_t1 = bi_al;
      end
      CMD_SUB: begin
        re_t0 = ar_al;  re_t1 = -br_al;
        im_t0 = ai_al;  im_t1 = -bi_al;
      end
      CMD_MUL: begin
        re_t0 = p0;  re_t1 = -p1;
        im_t0 = p2;  im_t1 = p3;
      end
      CMD_SCALE: begin
        re_t0 = p0;
        im_t0 = p1;
      end
      CMD_ACC_ADD: begin
        re_t0 = acc_re_x;  re_t1 = ar_al;
        im_t0 = acc_im_x;  im_t1 = ai_al;
      end
      CMD_ACC_SUB: begin
        re_t0 = acc_re_x;  re_t1 = -ar_al;
        im_t0 = acc_im_x;  im_t1 = -ai_al;
      end
      CMD_MAC: begin
        re_t0 = acc_re_x;  re_t1 = p0;   re_t2 = -p1;
        im_t0 = acc_im_x;  im_t1 = p2;   im_t2 = p3;
      end
      CMD_MSC: begin
        re_t0 = acc_re_x;  re_t1 = -p0;  re_t2 = p1;
        im_t0 = acc_im_x;  im_t1 = -p2;  im_t2 = -p3;
      end
      CMD_MAC_I: begin
        re_t0 = acc_re_x;  re_t1 = -p2;  re_t2 = -p3;
        im_t0 = acc_im_x;  im_t1 = p0;   im_t2 = -p1;
      end
      CMD_MSC_I: begin
        re_t0 = acc_re_x;  re_t1 = p2;   re_t2 = p3;
        im_t0 = acc_im_x;  im_t1 = -p0;  im_t2 = p1;
      end
      CMD_TIMES_I: begin
        re_t0 = -ai_al;
        im_t0 = ar_al;
      end
      CMD_TIMES_MINUS_I: begin
        re_t0 = ai_al;
        im_t0 = -ar_al;
      end
      CMD_NORM2: begin
        re_t0 = p0;  re_t1 = p1;
      end
      default: begin
        // unused command: hold the accumulator
        re_t0 = acc_re_x;
        im_t0 = acc_im_x;
      end
    endcase
  end

  // Exact sum, then clamp each part to the accumulator range.
  always_comb begin
    sum_re   = re_t0 + re_t1 + re_t2;
    sum_im   = im_t0 + im_t1 + im_t2;
    re_top   = sum_re[SUM_W-1:ACC_W-1];
    im_top   = sum_im[SUM_W-1:ACC_W-1];
    re_fit   = (&re_top) || !(|re_top);
    im_fit   = (&im_top) || !(|im_top);
    acc_re_d = re_fit ? sum_re[ACC_W-1:0] : (sum_re[SUM_W-1] ? ACC_MIN : ACC_MAX);
    acc_im_d = im_fit ? sum_im[ACC_W-1:0] : (sum_im[SUM_W-1] ? ACC_MIN : ACC_MAX);
    sat_d    = !re_fit || !im_fit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_i.payload;
    end
  end

  // The accumulator doubles as the result payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      acc_re_q  <= '0;
      acc_im_q  <= '0;
      sat_q     <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
      if (in_vld_q) begin
        acc_re_q <= acc_re_d;
        acc_im_q <= acc_im_d;
        sat_q    <= sat_d;
      end
    end
  end

  assign out_o.valid             = out_vld_q;
  assign out_o.payload.result_re = acc_re_q;
  assign out_o.payload.result_im = acc_im_q;
  assign out_o.payload.saturated = sat_q;

  a_sat_at_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && sat_q |->
      acc_re_q == ACC_MAX || acc_re_q == ACC_MIN ||
      acc_im_q == ACC_MAX || acc_im_q == ACC_MIN)
    else $error("saturated flag set with accumulator inside range");

  a_stall_holds_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(acc_re_q) && $stable(acc_im_q) && out_vld_q)
    else $error("accumulator changed while result stalled");

  a_in_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_vld_q)
    else $error("input transfer lost");

  a_item_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_vld_q |=> out_vld_q)
    else $error("item dropped between input and result register");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the complex MAC ALU
// Drives command transfers with random gaps and result back-pressure and
// tracks the saturating accumulator on the bench side. Every result transfer
// is compared field by field with the accumulator value the bench predicts.
// ----------------------------------------------------------------------------
module tb;
  import cmac_pkg::*;

  localparam int ITEM_COUNT   = 1500;
  localparam int TAIL_ITEMS   = 200;
  localparam int RUN_LEN      = 290;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd14;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

  localparam logic signed [OP_W-1:0] OP_MIN = {1'b1, {(OP_W-1){1'b0}}};
  localparam logic signed [OP_W-1:0] OP_MAX = {1'b0, {(OP_W-1){1'b1}}};

  localparam longint Q15_ONE = longint'(1) << FRAC_SH;
  localparam longint ACC_HI  = ACC_MAX;
  localparam longint ACC_LO  = ACC_MIN;

  // Tracks the accumulator and holds the results still owed by the block.
  class acc_tracker;
    longint    acc_re;
    longint    acc_im;
    cmac_out_t acc_due[$];
    int        err_count;

    function new();
      acc_re    = 0;
      acc_im    = 0;
      err_count = 0;
    endfunction

    function longint clamp_acc(longint v, inout bit sat);
      if (v > ACC_HI) begin
        sat = 1'b1;
        return ACC_HI;
      end
      if (v < ACC_LO) begin
        sat = 1'b1;
        return ACC_LO;
      end
      return v;
    endfunction

    function cmac_out_t step_accumulator(cmac_in_t c);
      longint    ar, ai, br, bi, rf;
      longint    mul_re, mul_im, nr, ni;
      bit        sat;
      cmac_out_t r;
      ar = $signed(c.first_re);
      ai = $signed(c.first_im);
      br = $signed(c.second_re);
      bi = $signed(c.second_im);
      rf = $signed(c.real_factor);
      // conjugating the most negative value yields +2^15, no wrap
      if (c.conj_first) ai = -ai;
      if (c.conj_second) bi = -bi;
      mul_re = ar * br - ai * bi;
      mul_im = ar * bi + ai * br;
      nr  = acc_re;
      ni  = acc_im;
      sat = 1'b0;
      case (c.command)
        CMD_COPY: begin
          nr = ar * Q15_ONE;
          ni = ai * Q15_ONE;
        end
        CMD_ADD: begin
          nr = (ar + br) * Q15_ONE;
          ni = (ai + bi) * Q15_ONE;
        end
        CMD_SUB: begin
          nr = (ar - br) * Q15_ONE;
          ni = (ai - bi) * Q15_ONE;
        end
        CMD_MUL: begin
          nr = mul_re;
          ni = mul_im;
        end
        CMD_SCALE: begin
          nr = ar * rf;
          ni = ai * rf;
        end
        CMD_ACC_ADD: begin
          nr = acc_re + ar * Q15_ONE;
          ni = acc_im + ai * Q15_ONE;
        end
        CMD_ACC_SUB: begin
          nr = acc_re - ar * Q15_ONE;
          ni = acc_im - ai * Q15_ONE;
        end
        CMD_MAC: begin
          nr = acc_re + mul_re;
          ni = acc_im + mul_im;
        end
        CMD_MSC: begin
          nr = acc_re - mul_re;
          ni = acc_im - mul_im;
        end
        CMD_MAC_I: begin
          nr = acc_re - mul_im;
          ni = acc_im + mul_re;
        end
        CMD_MSC_I: begin
          nr = acc_re + mul_im;
          ni = acc_im - mul_re;
        end
        CMD_TIMES_I: begin
          nr = -ai * Q15_ONE;
          ni = ar * Q15_ONE;
        end
        CMD_TIMES_MINUS_I: begin
          nr = ai * Q15_ONE;
          ni = -ar * Q15_ONE;
        end
        CMD_NORM2: begin
          nr = ar * ar + ai * ai;
          ni = 0;
        end
        default: ;  // spare codes hold the accumulator
      endcase
      acc_re = clamp_acc(nr, sat);
      acc_im = clamp_acc(ni, sat);
      r.result_re = acc_re[ACC_W-1:0];
      r.result_im = acc_im[ACC_W-1:0];
      r.saturated = sat;
      return r;
    endfunction

    function void note_command(cmac_in_t c);
      acc_due.push_back(step_accumulator(c));
    endfunction

    function int pending();
      return acc_due.size();
    endfunction

    task report(input string msg);
      err_count++;
      if (err_count <= 40) $display("tb: mismatch: %s", msg);
    endtask

    task check_result(input cmac_out_t got);
      cmac_out_t want;
      if (acc_due.size() == 0) begin
        report($sformatf("result with none outstanding: re=%0d im=%0d sat=%0b",
                         $signed(got.result_re), $signed(got.result_im), got.saturated));
        return;
      end
      want = acc_due.pop_front();
      if (got.result_re !== want.result_re)
        report($sformatf("result_re got %0d want %0d",
                         $signed(got.result_re), $signed(want.result_re)));
      if (got.result_im !== want.result_im)
        report($sformatf("result_im got %0d want %0d",
                         $signed(got.result_im), $signed(want.result_im)));
      if (got.saturated !== want.saturated)
        report($sformatf("saturated got %0b want %0b", got.saturated, want.saturated));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  cmac_in_if  in_if ();
  cmac_out_if out_if ();

  complex_mac_alu_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  acc_tracker tracker = new();

  bit hold_req;
  bit quiet_tail;
  int sent;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: FAIL");
    $finish;
  end

  function automatic cmac_in_t make_cmd(input logic [CMD_W-1:0] code,
                                        input bit cf, input bit cs,
                                        input logic signed [OP_W-1:0] ar, ai, br, bi, rf);
    cmac_in_t c;
    c.command     = code;
    c.conj_first  = cf;
    c.conj_second = cs;
    c.first_re    = ar;
    c.first_im    = ai;
    c.second_re   = br;
    c.second_im   = bi;
    c.real_factor = rf;
    return c;
  endfunction

  function automatic logic signed [OP_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return OP_MIN;
      1:       return OP_MAX;
      2:       return '0;
      3:       return '1;
      default: return OP_W'($urandom);
    endcase
  endfunction

  function automatic cmac_in_t random_cmd();
    return make_cmd(CMD_W'($urandom_range(0, 15)), 1'($urandom), 1'($urandom),
                    pick_operand(), pick_operand(), pick_operand(), pick_operand(),
                    pick_operand());
  endfunction

  // Entered and left at a falling edge; one command transfer per call.
  task automatic send_command(input cmac_in_t c, input bit may_idle);
    if (may_idle && !quiet_tail && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= c;
    do @(posedge clk_i); while (!in_if.ready);
    tracker.note_command(c);
    sent++;
    if (sent >= ITEM_COUNT - TAIL_ITEMS) quiet_tail = 1'b1;
    @(negedge clk_i);
  endtask

  // Clear, then push one accumulator part toward a rail until it clamps.
  task automatic accumulate_run(input bit use_imag, input bit go_up, input bit may_idle);
    logic [CMD_W-1:0] code;
    bit               cj;
    cmac_in_t         c;
    if (use_imag) code = go_up ? CMD_MAC_I : CMD_MSC_I;
    else          code = go_up ? CMD_MAC : CMD_MSC;
    send_command(make_cmd(CMD_COPY, 1'b0, 1'b0, '0, '0, pick_operand(), pick_operand(),
                          pick_operand()), may_idle);
    repeat (RUN_LEN) begin
      cj = 1'($urandom);
      // matching conjugate flags keep the product's real part near +2^31
      c = make_cmd(code, cj, cj,
                   OP_MIN + OP_W'($urandom_range(0, 63)),
                   OP_MIN + OP_W'($urandom_range(0, 63)),
                   OP_MIN + OP_W'($urandom_range(0, 63)),
                   OP_MAX - OP_W'($urandom_range(0, 63)),
                   pick_operand());
      if ($urandom_range(0, 9) == 0) begin
        c = random_cmd();
        c.command = CMD_W'($urandom_range(CMD_ACC_ADD, CMD_MSC_I));
      end
      send_command(c, may_idle);
    end
  endtask

  // Result side: random stall bursts plus one long hold-off on request.
  initial begin
    int stall_left;
    int hold_left;
    bit hold_taken;
    out_if.ready = 1'b0;
    stall_left   = 0;
    hold_left    = 0;
    hold_taken   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) tracker.check_result(out_if.payload);
    end
  end

  initial begin
    int  runs;
    bit  seg_idle;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    rst_ni        = 1'b0;
    hold_req      = 1'b0;
    quiet_tail    = 1'b0;
    sent          = 0;
    runs          = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // field extremes, every command, conjugated minimum, spare codes
    send_command(make_cmd(CMD_COPY, 0, 0, OP_MAX, OP_MIN, '0, '0, '0), 1);
    send_command(make_cmd(CMD_COPY, 1, 0, OP_MIN, OP_MIN, OP_MAX, OP_MAX, OP_MAX), 1);
    send_command(make_cmd(CMD_ADD, 0, 0, OP_MAX, OP_MAX, OP_MAX, OP_MAX, '0), 1);
    send_command(make_cmd(CMD_SUB, 0, 1, OP_MIN, OP_MIN, OP_MAX, OP_MIN, '0), 1);
    send_command(make_cmd(CMD_MUL, 1, 1, OP_MIN, OP_MIN, OP_MIN, OP_MIN, '0), 1);
    send_command(make_cmd(CMD_MUL, 0, 0, OP_MAX, OP_MIN, OP_MIN, OP_MAX, '1), 1);
    send_command(make_cmd(CMD_SCALE, 1, 0, OP_MIN, OP_MIN, '0, '0, OP_MIN), 1);
    send_command(make_cmd(CMD_SCALE, 0, 1, OP_MAX, OP_MIN, '1, '1, OP_MAX), 1);
    send_command(make_cmd(CMD_ACC_ADD, 0, 0, OP_MAX, OP_MAX, '0, '0, '0), 1);
    send_command(make_cmd(CMD_ACC_SUB, 1, 0, OP_MIN, OP_MIN, '0, '0, '0), 1);
    send_command(make_cmd(CMD_MAC, 0, 1, OP_MIN, OP_MAX, OP_MIN, OP_MIN, '0), 1);
    send_command(make_cmd(CMD_MSC, 1, 0, OP_MIN, OP_MIN, OP_MAX, OP_MIN, '0), 1);
    send_command(make_cmd(CMD_MAC_I, 1, 0, OP_MIN, OP_MIN, OP_MIN, OP_MAX, '0), 1);
    send_command(make_cmd(CMD_MSC_I, 1, 1, OP_MAX, OP_MIN, OP_MIN, OP_MIN, '0), 1);
    send_command(make_cmd(CMD_TIMES_I, 0, 0, OP_MIN, OP_MIN, '0, '0, '0), 1);
    send_command(make_cmd(CMD_TIMES_I, 1, 0, OP_MAX, OP_MIN, '0, '0, '0), 1);
    send_command(make_cmd(CMD_TIMES_MINUS_I, 1, 0, OP_MIN, OP_MIN, '0, '0, '0), 1);
    send_command(make_cmd(CMD_TIMES_MINUS_I, 0, 1, OP_MAX, OP_MAX, OP_MIN, OP_MIN, '0), 1);
    send_command(make_cmd(CMD_NORM2, 1, 0, OP_MIN, OP_MIN, '0, '0, '0), 1);
    send_command(make_cmd(CMD_NORM2, 0, 0, OP_MAX, OP_MAX, '0, '0, '0), 1);
    send_command(make_cmd(CMD_SPARE_LO, 1, 1, OP_MIN, OP_MAX, OP_MIN, OP_MAX, OP_MIN), 1);
    send_command(make_cmd(CMD_SPARE_HI, 0, 0, OP_MAX, OP_MIN, OP_MAX, OP_MIN, OP_MAX), 1);
    send_command(make_cmd(CMD_COPY, 0, 0, '0, '0, '0, '0, '1), 1);

    // long result hold-off while commands keep coming: fill up and stall input
    hold_req = 1'b1;
    repeat (24) send_command(random_cmd(), 0);

    while (sent < ITEM_COUNT) begin
      seg_idle = ($urandom_range(0, 3) != 0);
      if (runs < 4 && !quiet_tail && $urandom_range(0, 2) == 0) begin
        accumulate_run(runs[0], runs[1], seg_idle);
        runs++;
      end else begin
        repeat (25) send_command(random_cmd(), seg_idle);
      end
    end

    in_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.err_count == 0 && tracker.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
